/* rtl/core/lod_pkg.sv */
package lod_pkg;

    localparam int ChanDefault = 8;
    localparam int StateW      = 8;
    localparam int MaxReports  = 8;
    localparam int CntW        = $clog2(MaxReports);
    // power of two so the pointers wrap by themselves
    localparam int QueueDepth  = 2;
    localparam int PtrW        = $clog2(QueueDepth);
    localparam int CfgIdxW     = 3;

    localparam logic [7:0] LockoutReset = 8'd80;

    typedef enum logic [CfgIdxW-1:0] {
        CfgActiveLow = 3'd0,
        CfgLockout   = 3'd1,
        CfgAddress   = 3'd2,
        CfgType      = 3'd3,
        CfgEnabled   = 3'd4
    } cfg_index_t;

    typedef enum logic {
        ActTick    = 1'b0,
        ActRequest = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        CmdSet   = 2'd0,
        CmdGet   = 2'd1,
        CmdInfo  = 2'd2,
        CmdOther = 2'd3
    } command_t;

    typedef struct packed {
        logic [StateW-1:0] state_old;
        logic [StateW-1:0] state_new;
        logic [7:0]        address;
    } lod_entry_t;

endpackage

/* rtl/core/eight_channel_lockout_debouncer.sv */
// Eight-input lockout debouncer with feedback reports. The input side takes one request per
// cycle as long as the two-entry queue between front and back has room; a tick or bus request
// is classified and the channel state updated in the cycle it is accepted. The back walks the
// queued changes and drives one report per cycle while m_ready allows, so a tick with k level
// changes yields k reports (at most 8), and a matching GET request yields one. Requests
// that cause no report never reach the queue. Results sit in an output register, so a stalled
// consumer does not stop new requests until the queue fills. No clearing pass after reset.
module eight_channel_lockout_debouncer
    import lod_pkg::*;
#(
    parameter int CHANNELS = ChanDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [7:0]         s_raw_pins,
    input  logic [3:0]         s_req_type,
    input  logic [7:0]         s_req_address,
    input  logic [1:0]         s_req_command,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_pin_states,
    output logic [7:0]         m_report_address,
    output logic               m_is_last
);

    logic                push_valid, push_ready, pop_valid, pop_ready;
    lod_entry_t          push_entry, pop_entry;
    logic [CHANNELS-1:0] push_mask, pop_mask;

    assign cfg_ready = 1'b1;

    lod_front #(.CHANNELS(CHANNELS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_raw_pins    (s_raw_pins),
        .s_req_type    (s_req_type),
        .s_req_address (s_req_address),
        .s_req_command (s_req_command),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry),
        .push_mask     (push_mask)
    );

    lod_queue #(.CHANNELS(CHANNELS)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .push_mask  (push_mask),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .pop_mask   (pop_mask)
    );

    lod_back #(.CHANNELS(CHANNELS)) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_entry        (pop_entry),
        .pop_mask         (pop_mask),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pin_states     (m_pin_states),
        .m_report_address (m_report_address),
        .m_is_last        (m_is_last)
    );

endmodule

/* rtl/core/lod_front.sv */
module lod_front
    import lod_pkg::*;
#(
    parameter int CHANNELS = ChanDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [7:0]          s_raw_pins,
    input  logic [3:0]          s_req_type,
    input  logic [7:0]          s_req_address,
    input  logic [1:0]          s_req_command,
    input  logic                cfg_valid,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [7:0]          cfg_data,
    output logic                push_valid,
    input  logic                push_ready,
    output lod_entry_t          push_entry,
    output logic [CHANNELS-1:0] push_mask
);

    localparam int PW = (CHANNELS > StateW) ? CHANNELS : StateW;

    logic                active_low_reg;
    logic [7:0]          lockout_reg;
    logic [7:0]          address_reg;
    logic [3:0]          type_reg;
    logic                enabled_reg;

    logic [CHANNELS-1:0] level_reg, level_next;
    logic [7:0]          lock_reg  [CHANNELS];
    logic [7:0]          lock_next [CHANNELS];
    logic [CHANNELS-1:0] change;
    logic [CHANNELS-1:0] sample;
    logic [PW-1:0]       raw_w, cur_w, nxt_w;
    logic                accept, is_tick, req_hit;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;
    assign is_tick = (action_t'(s_action) == ActTick);
    // channels above the pin byte see a raw level of zero
    assign raw_w   = PW'(s_raw_pins);
    assign sample  = raw_w[CHANNELS-1:0] ^ {CHANNELS{active_low_reg}};

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            lock_next[i]  = lock_reg[i];
            level_next[i] = level_reg[i];
            change[i]     = 1'b0;
            if (lock_reg[i] != 8'd0) begin
                lock_next[i] = lock_reg[i] - 8'd1;
            end else if (sample[i] != level_reg[i]) begin
                change[i]     = 1'b1;
                level_next[i] = sample[i];
                lock_next[i]  = lockout_reg;
            end
        end
    end

    assign req_hit = enabled_reg && (s_req_type == type_reg) &&
                     (s_req_address == address_reg) &&
                     (command_t'(s_req_command) == CmdGet);

    assign cur_w = PW'(level_reg);
    assign nxt_w = PW'(level_next);

    always_comb begin
        push_valid = accept && (is_tick ? (|change) : req_hit);
        push_entry.address = address_reg;
        if (is_tick) begin
            push_entry.state_old = cur_w[StateW-1:0];
            push_entry.state_new = nxt_w[StateW-1:0];
            push_mask            = change;
        end else begin
            // a request reports the current byte as one single-step entry
            push_entry.state_old = cur_w[StateW-1:0];
            push_entry.state_new = cur_w[StateW-1:0];
            push_mask            = CHANNELS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_low_reg <= 1'b0;
            lockout_reg    <= LockoutReset;
            address_reg    <= 8'd0;
            type_reg       <= 4'd0;
            enabled_reg    <= 1'b0;
            level_reg      <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                lock_reg[i] <= 8'd0;
            end
        end else begin
            if (accept && is_tick) begin
                level_reg <= level_next;
                for (int i = 0; i < CHANNELS; i++) begin
                    lock_reg[i] <= lock_next[i];
                end
            end
            if (cfg_valid) begin
                unique case (cfg_index_t'(cfg_index))
                    CfgActiveLow: active_low_reg <= cfg_data[0];
                    CfgLockout:   lockout_reg    <= cfg_data;
                    CfgAddress:   address_reg    <= cfg_data;
                    CfgType:      type_reg       <= cfg_data[3:0];
                    CfgEnabled:   enabled_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* rtl/core/lod_queue.sv */
module lod_queue
    import lod_pkg::*;
#(
    parameter int CHANNELS = ChanDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  lod_entry_t          push_entry,
    input  logic [CHANNELS-1:0] push_mask,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lod_entry_t          pop_entry,
    output logic [CHANNELS-1:0] pop_mask
);

    lod_entry_t          entry_reg [QueueDepth];
    logic [CHANNELS-1:0] mask_reg  [QueueDepth];
    logic [PtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]       count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != (PtrW+1)'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign pop_mask   = mask_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
            mask_reg[wr_ptr_reg]  <= push_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

/* rtl/core/lod_back.sv */
module lod_back
    import lod_pkg::*;
#(
    parameter int CHANNELS = ChanDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  lod_entry_t          pop_entry,
    input  logic [CHANNELS-1:0] pop_mask,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_pin_states,
    output logic [7:0]          m_report_address,
    output logic                m_is_last
);

    localparam int PW = (CHANNELS > StateW) ? CHANNELS : StateW;

    logic                busy_reg;
    logic [CHANNELS-1:0] rem_reg, rem_next;
    lod_entry_t          cur_reg;
    logic [CntW-1:0]     cnt_reg;
    logic                m_valid_reg, m_is_last_reg;
    logic [7:0]          m_pin_states_reg, m_report_address_reg;

    logic                out_free, step, last_c;
    logic [PW-1:0]       rem_w, prefix_w;
    logic [StateW-1:0]   prefix8, pins_c;

    assign out_free = !m_valid_reg || m_ready;
    assign step     = busy_reg && out_free;

    // bits up to and including the lowest pending change
    assign rem_w    = PW'(rem_reg);
    assign prefix_w = rem_w ^ (rem_w - PW'(1));
    assign prefix8  = prefix_w[StateW-1:0];
    // state byte right after that change: lower changes applied, higher not yet
    assign pins_c   = (cur_reg.state_new & prefix8) | (cur_reg.state_old & ~prefix8);
    assign rem_next = rem_reg & (rem_reg - CHANNELS'(1));
    assign last_c   = (rem_next == '0) || (cnt_reg == CntW'(MaxReports - 1));

    assign pop_ready = !busy_reg || (step && last_c);

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            cur_reg <= pop_entry;
            rem_reg <= pop_mask;
        end else if (step) begin
            rem_reg <= rem_next;
        end
        if (step) begin
            m_pin_states_reg     <= pins_c;
            m_report_address_reg <= cur_reg.address;
            m_is_last_reg        <= last_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop_valid && pop_ready) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (step) begin
                busy_reg <= !last_c;
                cnt_reg  <= cnt_reg + 1'b1;
            end
            if (step) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pin_states     = m_pin_states_reg;
    assign m_report_address = m_report_address_reg;
    assign m_is_last        = m_is_last_reg;

    a_busy_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && (rem_reg == '0)))
        else $error("walker busy with no pending change");

    a_last_ends_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && last_c && !pop_valid) |=> !busy_reg)
        else $error("walker still busy after last report");

    a_load_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |=> (busy_reg && (cnt_reg == '0)))
        else $error("report count not cleared on new entry");

endmodule
